// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the range masking RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/rpmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rpmq_pkg
// Constants, types and register map of the range pixel masking quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rpmq_pkg;

    localparam int MASK_WIDTH  = 512;
    localparam int MASK_HEIGHT = 512;
    localparam int RANGE_SCALE = 1024;

    localparam int MASK_BITS = MASK_WIDTH * MASK_HEIGHT;
    localparam int MASK_AW   = $clog2(MASK_BITS);

    localparam int FRAME_MAX = 512;
    localparam int COL_W     = 9;
    localparam int ROW_W     = 16;
    localparam int POS_W     = 9;
    localparam int FW_W      = 10;
    localparam int SNR_W     = 24;
    localparam int THR_W     = 23;
    localparam int LIM_W     = 31;
    localparam int RNG_W     = 32;
    localparam int OUT_W     = 16;
    localparam int WADDR_W   = 18;

    localparam int PX_W   = COL_W + POS_W;
    localparam int PY_W   = ROW_W + POS_W;
    localparam int MX_W   = PX_W + 1;
    localparam int MY_W   = PY_W + 1;
    localparam int MWC_W  = $clog2(MASK_WIDTH + 1);
    localparam int ADDR_W = MY_W + MWC_W + 1;

    localparam int RS_W     = $clog2(RANGE_SCALE + 1);
    localparam int QP_W     = LIM_W + RS_W + 1;
    localparam int Q_SHIFT  = 16;
    localparam int Q_ROUND  = 32768;
    localparam int Q_MAX    = 65535;

    localparam int CFG_NUM = 8;
    localparam int CFG_DW  = 32;
    localparam int CFG_AW  = $clog2(CFG_NUM * 4);
    localparam int CFG_IW  = $clog2(CFG_NUM);

    typedef enum logic [CFG_IW-1:0] {
        REG_START_ROW   = 3'd0,
        REG_START_COL   = 3'd1,
        REG_STEP_ROW    = 3'd2,
        REG_STEP_COL    = 3'd3,
        REG_FRAME_WIDTH = 3'd4,
        REG_DISABLE     = 3'd5,
        REG_SNR_THR     = 3'd6,
        REG_RANGE_LIMIT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0] start_row;
        logic [POS_W-1:0] start_col;
        logic [POS_W-1:0] step_row;
        logic [POS_W-1:0] step_col;
        logic [FW_W-1:0]  frame_width;
        logic             disable_masking;
        logic [THR_W-1:0] snr_threshold;
        logic [LIM_W-1:0] range_limit;
    } t_cfg;

    localparam logic [POS_W-1:0] RST_START_ROW   = '0;
    localparam logic [POS_W-1:0] RST_START_COL   = '0;
    localparam logic [POS_W-1:0] RST_STEP_ROW    = POS_W'(1);
    localparam logic [POS_W-1:0] RST_STEP_COL    = POS_W'(1);
    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH = FW_W'(512);
    localparam logic             RST_DISABLE     = 1'b0;
    localparam logic [THR_W-1:0] RST_SNR_THR     = '0;
    localparam logic [LIM_W-1:0] RST_RANGE_LIMIT = '1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

endpackage

`default_nettype wire

// ===== src/rpmq_in_if.sv =====
// ----------------------------------------------------------------------------
// rpmq_in_if
// Input channel: pixel items and mask write items with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpmq_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic               frame_start;
    logic signed [31:0] range_in;
    logic [23:0]        snr_sum;
    logic               minmax_flag;
    logic [17:0]        mask_addr;
    logic               mask_bit;

    modport source (
        output valid, action, frame_start, range_in, snr_sum, minmax_flag,
               mask_addr, mask_bit,
        input  ready
    );

    modport sink (
        input  valid, action, frame_start, range_in, snr_sum, minmax_flag,
               mask_addr, mask_bit,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/rpmq_out_if.sv =====
// ----------------------------------------------------------------------------
// rpmq_out_if
// Output channel: quantized range items with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpmq_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] range_out;
    logic        pixel_masked;

    modport source (
        output valid, range_out, pixel_masked,
        input  ready
    );

    modport sink (
        input  valid, range_out, pixel_masked,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/rpmq_ram.sv =====
// ----------------------------------------------------------------------------
// rpmq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/rpmq_cfg.sv =====
// ----------------------------------------------------------------------------
// rpmq_cfg
// APB register file holding the masking and mapping configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmq_cfg import rpmq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_cfg_idx idx;
    logic     wr;

    assign idx    = t_cfg_idx'(paddr[CFG_AW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_row       <= RST_START_ROW;
            r_cfg.start_col       <= RST_START_COL;
            r_cfg.step_row        <= RST_STEP_ROW;
            r_cfg.step_col        <= RST_STEP_COL;
            r_cfg.frame_width     <= RST_FRAME_WIDTH;
            r_cfg.disable_masking <= RST_DISABLE;
            r_cfg.snr_threshold   <= RST_SNR_THR;
            r_cfg.range_limit     <= RST_RANGE_LIMIT;
        end else if (wr) begin
            case (idx)
                REG_START_ROW:   r_cfg.start_row       <= pwdata[POS_W-1:0];
                REG_START_COL:   r_cfg.start_col       <= pwdata[POS_W-1:0];
                REG_STEP_ROW:    r_cfg.step_row        <= pwdata[POS_W-1:0];
                REG_STEP_COL:    r_cfg.step_col        <= pwdata[POS_W-1:0];
                REG_FRAME_WIDTH: r_cfg.frame_width     <= pwdata[FW_W-1:0];
                REG_DISABLE:     r_cfg.disable_masking <= pwdata[0];
                REG_SNR_THR:     r_cfg.snr_threshold   <= pwdata[THR_W-1:0];
                REG_RANGE_LIMIT: r_cfg.range_limit     <= pwdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START_ROW:   prdata = CFG_DW'(r_cfg.start_row);
            REG_START_COL:   prdata = CFG_DW'(r_cfg.start_col);
            REG_STEP_ROW:    prdata = CFG_DW'(r_cfg.step_row);
            REG_STEP_COL:    prdata = CFG_DW'(r_cfg.step_col);
            REG_FRAME_WIDTH: prdata = CFG_DW'(r_cfg.frame_width);
            REG_DISABLE:     prdata = CFG_DW'(r_cfg.disable_masking);
            REG_SNR_THR:     prdata = CFG_DW'(r_cfg.snr_threshold);
            REG_RANGE_LIMIT: prdata = CFG_DW'(r_cfg.range_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/rpmq_pos.sv =====
// ----------------------------------------------------------------------------
// rpmq_pos
// Raster column and row counters with frame restart and row wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmq_pos import rpmq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_frame_start,
    input  wire logic [FW_W-1:0]  i_frame_width,
    output logic      [COL_W-1:0] o_col,
    output logic      [ROW_W-1:0] o_row
);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [FW_W-1:0]  eff_width;
    logic [FW_W-1:0]  col_inc;

    // The pixel that carries the frame flag sits at the origin.
    assign o_col = i_frame_start ? '0 : r_col;
    assign o_row = i_frame_start ? '0 : r_row;

    always_comb begin
        if (i_frame_width == '0 || i_frame_width > FW_W'(FRAME_MAX)) begin
            eff_width = FW_W'(FRAME_MAX);
        end else begin
            eff_width = i_frame_width;
        end
        col_inc = FW_W'(o_col) + FW_W'(1);
        if (col_inc >= eff_width) begin
            n_col = '0;
            n_row = o_row + ROW_W'(1);
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = o_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ===== src/rpmq_core.sv =====
// ----------------------------------------------------------------------------
// rpmq_core
// Mask store, clearing pass and the three-stage masking and scaling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rpmq_core import rpmq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_action,
    input  wire logic                    i_frame_start,
    input  wire logic signed [RNG_W-1:0] i_range_in,
    input  wire logic [SNR_W-1:0]        i_snr_sum,
    input  wire logic                    i_minmax_flag,
    input  wire logic [WADDR_W-1:0]      i_mask_addr,
    input  wire logic                    i_mask_bit,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic      [OUT_W-1:0]        o_range_out,
    output logic                         o_pixel_masked
);

    localparam logic [MASK_AW-1:0] CLR_LAST = MASK_AW'(MASK_BITS - 1);

    logic en;
    logic acc;
    logic pix;
    logic wr;

    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;

    logic               r_clr_active;
    logic [MASK_AW-1:0] r_clr_addr;

    logic                    r_a_valid;
    logic [PX_W-1:0]         r_a_px;
    logic [PY_W-1:0]         r_a_py;
    logic signed [RNG_W-1:0] r_a_range;
    logic                    r_a_early;

    logic             r_b_valid;
    logic [OUT_W-1:0] r_b_q;
    logic             r_b_early;
    logic             r_b_chk;

    logic             r_o_valid;
    logic [OUT_W-1:0] r_o_range;
    logic             r_o_masked;

    logic               early;
    logic [ADDR_W-1:0]  waddr_ext;
    logic               w_in_store;
    logic [MX_W-1:0]    mx;
    logic [MY_W-1:0]    my;
    logic [ADDR_W-1:0]  addr;
    logic               in_store;
    logic [QP_W-1:0]    qp;
    logic [QP_W-1:0]    qs;
    logic [OUT_W-1:0]   q;
    logic               masked;

    logic               ram_we;
    logic [MASK_AW-1:0] ram_waddr;
    logic               ram_wdata;
    logic               ram_rdata;

    assign en         = !r_o_valid || i_out_ready;
    assign o_in_ready = en && !r_clr_active;
    assign acc        = i_in_valid && o_in_ready;
    assign pix        = acc && (i_action == ACT_PIXEL);
    assign wr         = acc && (i_action == ACT_WRITE);

    rpmq_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (pix),
        .i_frame_start (i_frame_start),
        .i_frame_width (i_cfg.frame_width),
        .o_col         (col),
        .o_row         (row)
    );

    always_comb begin
        early = !i_cfg.disable_masking && (i_minmax_flag
              || ({1'b0, i_snr_sum} < {i_cfg.snr_threshold, 1'b0})
              || (i_range_in > $signed({1'b0, i_cfg.range_limit})));
        waddr_ext  = ADDR_W'(i_mask_addr);
        w_in_store = waddr_ext < ADDR_W'(MASK_BITS);
    end

    always_comb begin
        mx = MX_W'(i_cfg.start_col) + MX_W'(r_a_px);
        my = MY_W'(i_cfg.start_row) + MY_W'(r_a_py);
        addr = ADDR_W'(mx) + ADDR_W'(my) * ADDR_W'(MASK_WIDTH);
        in_store = addr < ADDR_W'(MASK_BITS);
        qp = QP_W'(r_a_range[LIM_W-1:0]) * QP_W'(RANGE_SCALE) + QP_W'(Q_ROUND);
        qs = qp >> Q_SHIFT;
        if (r_a_range[RNG_W-1] || r_a_range == '0) begin
            q = '0;
        end else if (qs > QP_W'(Q_MAX)) begin
            q = '1;
        end else begin
            q = qs[OUT_W-1:0];
        end
    end

    always_comb begin
        if (r_clr_active) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = wr && w_in_store;
            ram_waddr = waddr_ext[MASK_AW-1:0];
            ram_wdata = i_mask_bit;
        end
    end

    rpmq_ram #(
        .WIDTH (1),
        .DEPTH (MASK_BITS)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (en),
        .i_raddr (addr[MASK_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign masked = r_b_early || (r_b_chk && !ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + MASK_AW'(1);
            if (r_clr_addr == CLR_LAST) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= pix;
            r_b_valid <= r_a_valid;
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_px     <= PX_W'(col) * PX_W'(i_cfg.step_col);
            r_a_py     <= PY_W'(row) * PY_W'(i_cfg.step_row);
            r_a_range  <= i_range_in;
            r_a_early  <= early;
            r_b_q      <= q;
            r_b_early  <= r_a_early;
            r_b_chk    <= !i_cfg.disable_masking && in_store;
            r_o_range  <= masked ? '0 : r_b_q;
            r_o_masked <= masked;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_range_out    = r_o_range;
    assign o_pixel_masked = r_o_masked;

    `ASSERT_NEXT(a_pix_enters, i_clk, i_rst_n, pix, r_a_valid)
    `ASSERT_NEXT(a_clr_done, i_clk, i_rst_n, r_clr_active && r_clr_addr == CLR_LAST,
                 !r_clr_active)
    `ASSERT_NEXT(a_b_holds, i_clk, i_rst_n, r_b_valid && !en, r_b_valid)

endmodule

`default_nettype wire

// ===== src/range_pixel_masking_quantizer.sv =====
// ----------------------------------------------------------------------------
// range_pixel_masking_quantizer
// A pixel item's result passes the registers r_a, r_b and r_o on its way out.
// Throughput: one item per cycle; the output register stalls the whole pipe.
// Mask write items give no result.
// Reset: after reset the mask store is cleared, one bit a cycle, over all
// MASK_WIDTH * MASK_HEIGHT (262144) bits; no item is accepted until the clear is done.
// ----------------------------------------------------------------------------
`default_nettype none

module range_pixel_masking_quantizer import rpmq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    rpmq_in_if.sink                i_pix,
    rpmq_out_if.source             o_res
);

    t_cfg cfg;

    rpmq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rpmq_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_pix.valid),
        .o_in_ready     (i_pix.ready),
        .i_action       (i_pix.action),
        .i_frame_start  (i_pix.frame_start),
        .i_range_in     (i_pix.range_in),
        .i_snr_sum      (i_pix.snr_sum),
        .i_minmax_flag  (i_pix.minmax_flag),
        .i_mask_addr    (i_pix.mask_addr),
        .i_mask_bit     (i_pix.mask_bit),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_range_out    (o_res.range_out),
        .o_pixel_masked (o_res.pixel_masked)
    );

endmodule

`default_nettype wire

// ===== bench/range_pixel_masking_quantizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_pixel_masking_quantizer_tb
// Streams mask loads and depth pixels through the quantizer. A short table of
// items is checked against hand-worked results. Random frames then follow
// under several register settings, with random idling on both channels. Their
// results are compared with an in-bench model of the masking and scaling.
// ----------------------------------------------------------------------------

module range_pixel_masking_quantizer_tb import rpmq_pkg::*;;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DIR_ROWS    = 19;
    localparam int PHASES      = 8;

    typedef struct packed {
        logic        action;
        logic        frame_start;
        logic [31:0] range_in;
        logic [23:0] snr_sum;
        logic        minmax_flag;
        logic [17:0] mask_addr;
        logic        mask_bit;
    } t_pix_item;

    typedef struct packed {
        logic [15:0] range_out;
        logic        pixel_masked;
    } t_range_res;

    typedef struct packed {
        t_pix_item  it;
        logic       typed;
        t_range_res want;
    } t_dir_row;

    typedef struct packed {
        int sr, sc, str, stc, fw, dis, thr, lim;
        int cols, npix, frames, idle, noise;
    } t_phase;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    rpmq_in_if  pix ();
    rpmq_out_if res ();

    range_pixel_masking_quantizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix),
        .o_res   (res)
    );

    t_cfg        regs;
    logic [8:0]  pix_col;
    logic [15:0] pix_row;
    bit          mask_img [MASK_BITS];
    t_range_res  pending_ranges [$];
    int          fail_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    int send_pct_of [4] = '{0, 77, 0, 29};
    int recv_pct_of [4] = '{0, 0, 77, 29};

    // Rows run under the reset register values, on a mask that starts all zero.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{'{ACT_WRITE, 1'b0, 32'h0, 24'h0, 1'b0, 18'd0, 1'b1}, 1'b0, '{16'd0, 1'b0}},
        '{'{ACT_WRITE, 1'b0, 32'h0, 24'h0, 1'b0, 18'd1, 1'b1}, 1'b0, '{16'd0, 1'b0}},
        '{'{ACT_WRITE, 1'b0, 32'h0, 24'h0, 1'b0, 18'd2, 1'b1}, 1'b0, '{16'd0, 1'b0}},
        '{'{ACT_WRITE, 1'b0, 32'h0, 24'h0, 1'b0, 18'd3, 1'b1}, 1'b0, '{16'd0, 1'b0}},
        '{'{ACT_WRITE, 1'b0, 32'h0, 24'h0, 1'b0, 18'd4, 1'b1}, 1'b0, '{16'd0, 1'b0}},
        '{'{ACT_WRITE, 1'b0, 32'h0, 24'h0, 1'b0, 18'h3FFFF, 1'b1}, 1'b0, '{16'd0, 1'b0}},
        '{'{ACT_PIXEL, 1'b1, 32'h0001_0000, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1,
          '{16'd1024, 1'b0}},
        '{'{ACT_PIXEL, 1'b0, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b0, 18'd0, 1'b0}, 1'b1,
          '{16'd65535, 1'b0}},
        '{'{ACT_PIXEL, 1'b0, 32'h8000_0000, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1,
          '{16'd0, 1'b0}},
        '{'{ACT_PIXEL, 1'b0, 32'd31, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1, '{16'd0, 1'b0}},
        '{'{ACT_PIXEL, 1'b0, 32'd32, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1, '{16'd1, 1'b0}},
        '{'{ACT_PIXEL, 1'b0, 32'h0001_0000, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1,
          '{16'd0, 1'b1}},
        '{'{ACT_PIXEL, 1'b1, 32'h0001_0000, 24'h0, 1'b1, 18'd0, 1'b0}, 1'b1,
          '{16'd0, 1'b1}},
        '{'{ACT_WRITE, 1'b1, 32'h0, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b0, '{16'd0, 1'b0}},
        '{'{ACT_PIXEL, 1'b0, 32'h0001_0000, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1,
          '{16'd1024, 1'b0}},
        '{'{ACT_PIXEL, 1'b1, 32'h0001_0000, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1,
          '{16'd0, 1'b1}},
        '{'{ACT_PIXEL, 1'b0, 32'hFFFF_FFFF, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1,
          '{16'd0, 1'b0}},
        '{'{ACT_PIXEL, 1'b0, 32'h0, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b1, '{16'd0, 1'b0}},
        '{'{ACT_PIXEL, 1'b0, 32'h0400_0000, 24'h0, 1'b0, 18'd0, 1'b0}, 1'b0,
          '{16'd0, 1'b0}}
    };

    t_phase plan [PHASES] = '{
        '{0, 0, 1, 1, 4, 0, 0, 32'h7FFF_FFFF, 4, 12, 6, 0, 1},
        '{3, 5, 2, 3, 7, 0, 32'h180, 32'h4_0000, 7, 14, 5, 1, 1},
        '{511, 511, 511, 511, 3, 0, 32'h7F_FFFF, 0, 3, 9, 5, 2, 1},
        '{0, 40, 1, 0, 0, 0, 32'h20, 32'h7FFF_FFFF, 512, 530, 1, 3, 0},
        '{10, 20, 1, 2, 1023, 1, 32'h2000, 32'h3_0000, 512, 24, 3, 3, 1},
        '{7, 1, 1, 1, 1, 0, 32'h80, 32'h7FFF_FFFF, 1, 40, 1, 0, 0},
        '{100, 200, 3, 5, 16, 0, 32'h300, 32'h20_0000, 16, 48, 2, 1, 1},
        '{0, 0, 1, 1, 512, 0, 0, 32'h7FFF_FFFF, 512, 40, 3, 2, 1}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_range_res want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_ranges.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: range_out %0d masked %0b",
                             res.range_out, res.pixel_masked);
            end else begin
                want = pending_ranges.pop_front();
                if (res.range_out !== want.range_out ||
                    res.pixel_masked !== want.pixel_masked) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected range_out %0d masked %0b, got %0d %0b",
                                 want.range_out, want.pixel_masked,
                                 res.range_out, res.pixel_masked);
                end
            end
        end
    end

    function automatic longint unsigned mask_index(int col, int row);
        longint unsigned mx;
        longint unsigned my;
        mx = 64'(regs.start_col) + 64'(col) * 64'(regs.step_col);
        my = 64'(regs.start_row) + 64'(row) * 64'(regs.step_row);
        return mx + 64'(MASK_WIDTH) * my;
    endfunction

    function automatic t_range_res quantize_pixel(t_pix_item it);
        longint unsigned addr;
        longint          rng;
        longint          q;
        int              eff_w;
        bit              hole;
        bit              masked;
        t_range_res      r;
        if (it.frame_start) begin
            pix_col = '0;
            pix_row = '0;
        end
        rng  = longint'($signed(it.range_in));
        addr = mask_index(int'(pix_col), int'(pix_row));
        hole = (addr < 64'(MASK_BITS)) && !mask_img[addr[17:0]];
        masked = !regs.disable_masking &&
                 (it.minmax_flag || (32'(it.snr_sum) < (32'(regs.snr_threshold) << 1)) ||
                  hole || (rng > longint'({33'd0, regs.range_limit})));
        q = 0;
        if (!masked && rng > 0) begin
            q = (rng * RANGE_SCALE + 32768) >>> 16;
            if (q > 65535)
                q = 65535;
        end
        r.range_out    = 16'(q);
        r.pixel_masked = masked;
        eff_w = (regs.frame_width == 0 || regs.frame_width > FRAME_MAX) ?
                FRAME_MAX : int'(regs.frame_width);
        if (int'(pix_col) + 1 >= eff_w) begin
            pix_col = '0;
            pix_row = pix_row + 16'd1;
        end else begin
            pix_col = pix_col + 9'd1;
        end
        return r;
    endfunction

    function automatic t_pix_item make_write(logic [17:0] addr, logic b);
        t_pix_item it;
        it.action      = ACT_WRITE;
        it.frame_start = 1'($urandom);
        it.range_in    = $urandom;
        it.snr_sum     = 24'($urandom);
        it.minmax_flag = 1'($urandom);
        it.mask_addr   = addr;
        it.mask_bit    = b;
        return it;
    endfunction

    function automatic t_pix_item make_pixel(logic fs);
        t_pix_item it;
        int        sel;
        it.action      = ACT_PIXEL;
        it.frame_start = fs;
        it.mask_addr   = 18'($urandom);
        it.mask_bit    = 1'($urandom);
        it.minmax_flag = ($urandom_range(0, 9) == 0);
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: it.range_in = $urandom_range(0, 32'h0040_0000);
            4: it.range_in = 32'(regs.range_limit) + 32'($urandom_range(0, 4)) - 32'd2;
            5: it.range_in = {1'b1, 31'($urandom)};
            6: it.range_in = {10'd0, 16'($urandom), 6'd31} + 32'($urandom_range(0, 1));
            7: begin
                case ($urandom_range(0, 3))
                    0: it.range_in = 32'h7FFF_FFFF;
                    1: it.range_in = 32'h8000_0000;
                    2: it.range_in = 32'h0;
                    default: it.range_in = 32'h1;
                endcase
            end
            default: it.range_in = $urandom;
        endcase
        if ($urandom_range(0, 2) == 0)
            it.snr_sum = 24'({regs.snr_threshold, 1'b0}) + 24'($urandom_range(0, 2)) - 24'd1;
        else
            it.snr_sum = 24'($urandom);
        return it;
    endfunction

    task automatic push_item(input t_pix_item it, input logic typed, input t_range_res want);
        t_range_res got;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.action      <= it.action;
        pix.frame_start <= it.frame_start;
        pix.range_in    <= it.range_in;
        pix.snr_sum     <= it.snr_sum;
        pix.minmax_flag <= it.minmax_flag;
        pix.mask_addr   <= it.mask_addr;
        pix.mask_bit    <= it.mask_bit;
        pix.valid       <= 1'b1;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        if (it.action == ACT_PIXEL) begin
            got = quantize_pixel(it);
            pending_ranges.push_back(typed ? want : got);
        end else if (32'(it.mask_addr) < MASK_BITS) begin
            mask_img[it.mask_addr] = it.mask_bit;
        end
    endtask

    task automatic settle(input int extra);
        @(negedge i_clk);
        pix.valid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(int'(idx) * 4);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_START_ROW:   regs.start_row       = val[POS_W-1:0];
            REG_START_COL:   regs.start_col       = val[POS_W-1:0];
            REG_STEP_ROW:    regs.step_row        = val[POS_W-1:0];
            REG_STEP_COL:    regs.step_col        = val[POS_W-1:0];
            REG_FRAME_WIDTH: regs.frame_width     = val[FW_W-1:0];
            REG_DISABLE:     regs.disable_masking = val[0];
            REG_SNR_THR:     regs.snr_threshold   = val[THR_W-1:0];
            REG_RANGE_LIMIT: regs.range_limit     = val[LIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_phase          p;
        int              vals [8];
        int              rows;
        longint unsigned a;
        pix.valid       = 1'b0;
        pix.action      = ACT_PIXEL;
        pix.frame_start = 1'b0;
        pix.range_in    = '0;
        pix.snr_sum     = '0;
        pix.minmax_flag = 1'b0;
        pix.mask_addr   = '0;
        pix.mask_bit    = 1'b0;
        res.ready       = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_rst_n         = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        pix_col         = '0;
        pix_row         = '0;
        regs = '{RST_START_ROW, RST_START_COL, RST_STEP_ROW, RST_STEP_COL,
                 RST_FRAME_WIDTH, RST_DISABLE, RST_SNR_THR, RST_RANGE_LIMIT};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            push_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
        settle(8);

        for (int ph = 0; ph < PHASES; ph++) begin
            p = plan[ph];
            send_idle_pct  = send_pct_of[p.idle];
            recv_stall_pct = recv_pct_of[p.idle];
            vals = '{p.sr, p.sc, p.str, p.stc, p.fw, p.dis, p.thr, p.lim};
            for (int i = 0; i < 8; i++)
                cfg_write(t_cfg_idx'(i), 32'(vals[i]));

            // Load mask bits at columns 0-11 and the last column of the first rows.
            rows = p.npix / p.cols + 1;
            if (rows > 8)
                rows = 8;
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < p.cols; c++) begin
                    if (c < 12 || c == p.cols - 1) begin
                        a = mask_index(c, r);
                        if (a < 64'(MASK_BITS))
                            push_item(make_write(18'(a), $urandom_range(0, 4) != 0),
                                      1'b0, '0);
                    end
                end
            end

            for (int f = 0; f < p.frames; f++) begin
                if (f == p.frames / 2 && f != 0)
                    settle(0);
                for (int k = 0; k < p.npix; k++) begin
                    if (p.noise != 0 && $urandom_range(0, 99) < 10)
                        push_item(make_write(18'($urandom), 1'($urandom)), 1'b0, '0);
                    push_item(make_pixel(k == 0 ||
                                         (p.noise != 0 && $urandom_range(0, 99) < 3)),
                              1'b0, '0);
                end
            end
            settle(8);
        end

        if (fail_count == 0 && pending_ranges.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
